// ===== design/mdob_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mdob_pkg
// constants, register indexes and helpers for the motion deadband / overload
// burst block
// ----------------------------------------------------------------------------
package mdob_pkg;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        CFG_ENERGY_DB   = 3'd0,
        CFG_ROT_DB      = 3'd1,
        CFG_THRESHOLD   = 3'd2,
        CFG_CHARGE_RATE = 3'd3,
        CFG_DRAIN_RATE  = 3'd4,
        CFG_COOLDOWN    = 3'd5,
        CFG_TILT_OFFSET = 3'd6,
        CFG_GRACE       = 3'd7
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_W       = 136;
    localparam int OUT_W      = 104;

    // full overload level, 1.0
    localparam logic [16:0] FULL_LEVEL = 17'd65536;

    // tilt clamp, hundredths of a degree
    localparam logic signed [16:0] TILT_LIMIT = 17'sd9000;
    localparam logic [13:0] TILT_LIMIT_MAG    = 14'd9000;

    // mag * 16384 / 9000 == (mag * TILT_RECIP) >> 25, exact for mag <= 9000
    localparam logic [25:0] TILT_RECIP = 26'd61083980;
    localparam int TILT_SHIFT          = 25;

    // x / 15625 == (x * DIV_RECIP) >> 44, exact for x < 2^30
    localparam logic [30:0] DIV_RECIP = 31'd1125899907;
    localparam int DIV_SHIFT          = 44;

    // (product >> 6) above this gives a change of at least one full level
    localparam logic [29:0] DIV_SAT = 30'd1024000000;

    // rotation deadband: magnitude below the band reads zero
    function automatic logic signed [15:0] dead_rot(
        input logic signed [15:0] r,
        input logic [14:0]        db
    );
        logic [15:0] mag;
        mag = r[15] ? 16'(-r) : 16'(r);
        dead_rot = (mag < {1'b0, db}) ? 16'sd0 : r;
    endfunction

endpackage
`default_nettype wire

// ===== design/motion_deadband_overload_burst_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// motion_deadband_overload_burst_top
// motion sample conditioning (warm-up, deadbands, tilt scaling) with an
// overload level that charges and drains over time and emits a burst
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  s_tdata, 136 bits, one motion sample
// m_*       out        m_tvalid/m_tready  m_tdata, 104 bits, one result
// cfg_*     in         cfg_we             cfg_index, cfg_data
//
// one sample per clock sustained while m_tready stays high; four register stages from accept to result
// (conditioning, rate and tilt multiplies, divide by reciprocal, level update)
// the level and last burst time close their loop in the output stage only
// each stage has its own valid and moves whenever the stage after it has room,
// so input is still taken behind a stalled output until all four stages are full
// asynchronous active-low reset clears the stage valids, configuration registers and state
//
module motion_deadband_overload_burst_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [mdob_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mdob_pkg::CFG_DATA_W-1:0]    cfg_data,
    // sample stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // energy, rot_x, rot_y, rot_z, tilt, timestamp_ms, delta_us
    input  wire logic [mdob_pkg::IN_W-1:0]          s_tdata,
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // energy_out, rot_x_out, rot_y_out, rot_z_out, tilt_norm, overload_level,
    // burst, zero padding
    output logic [mdob_pkg::OUT_W-1:0]              m_tdata
);
    import mdob_pkg::*;

    // configuration registers
    logic [15:0]        energy_db_reg;
    logic [14:0]        rot_db_reg;
    logic [15:0]        threshold_reg;
    logic [23:0]        charge_rate_reg;
    logic [23:0]        drain_rate_reg;
    logic [15:0]        cooldown_reg;
    logic signed [15:0] tilt_offset_reg;
    logic [15:0]        grace_reg;

    // unpacked input fields
    logic [15:0]        in_energy;
    logic signed [15:0] in_rot_x;
    logic signed [15:0] in_rot_y;
    logic signed [15:0] in_rot_z;
    logic signed [15:0] in_tilt;
    logic [31:0]        in_ts;
    logic [23:0]        in_dt;

    // stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy_out;

    // stage 1: conditioned sample
    logic [15:0]        e1_reg;
    logic signed [15:0] rx1_reg, ry1_reg, rz1_reg;
    logic               tneg1_reg;
    logic [13:0]        tmag1_reg;
    logic               chg1_reg;
    logic [23:0]        rate1_reg;
    logic [23:0]        dt1_reg;
    logic [31:0]        ts1_reg;

    // stage 2: products
    logic [15:0]        e2_reg;
    logic signed [15:0] rx2_reg, ry2_reg, rz2_reg;
    logic               tneg2_reg;
    logic [39:0]        tprod2_reg;
    logic               chg2_reg;
    logic [47:0]        rprod2_reg;
    logic [31:0]        ts2_reg;

    // stage 3: tilt result and reciprocal product
    logic [15:0]        e3_reg;
    logic signed [15:0] rx3_reg, ry3_reg, rz3_reg;
    logic signed [15:0] tn3_reg;
    logic               chg3_reg;
    logic [60:0]        qprod3_reg;
    logic [31:0]        ts3_reg;

    // output register and state
    logic [15:0]        e_out_reg;
    logic signed [15:0] rx_out_reg, ry_out_reg, rz_out_reg;
    logic signed [15:0] tn_out_reg;
    logic [16:0]        lvl_out_reg;
    logic               burst_out_reg;
    logic [16:0]        level_reg;
    logic [31:0]        last_burst_reg;

    // stage 1 logic
    logic               grace;
    logic [15:0]        e1_next;
    logic signed [15:0] rx1_next, ry1_next, rz1_next;
    logic signed [16:0] tdiff;
    logic               tneg1_next;
    logic [13:0]        tmag1_next;
    logic               chg1_next;

    // stage 3 logic
    logic [41:0]        pdiv;
    logic [29:0]        nsat;
    logic [14:0]        tq;

    // output stage logic
    logic [16:0]        inc;
    logic               cool;
    logic [17:0]        sum;
    logic [16:0]        lv;
    logic [16:0]        level_next;
    logic [31:0]        last_burst_next;
    logic [16:0]        shown;
    logic               burst;

    assign in_energy = s_tdata[15:0];
    assign in_rot_x  = s_tdata[31:16];
    assign in_rot_y  = s_tdata[47:32];
    assign in_rot_z  = s_tdata[63:48];
    assign in_tilt   = s_tdata[79:64];
    assign in_ts     = s_tdata[111:80];
    assign in_dt     = s_tdata[135:112];

    // a stage takes new data when it is empty or its content moves on
    assign rdy_out  = !out_valid_reg || m_tready;
    assign rdy3     = !v3_reg || rdy_out;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_db_reg   <= '0;
            rot_db_reg      <= '0;
            threshold_reg   <= '0;
            charge_rate_reg <= '0;
            drain_rate_reg  <= '0;
            cooldown_reg    <= '0;
            tilt_offset_reg <= '0;
            grace_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ENERGY_DB:   energy_db_reg   <= cfg_data[15:0];
                CFG_ROT_DB:      rot_db_reg      <= cfg_data[14:0];
                CFG_THRESHOLD:   threshold_reg   <= cfg_data[15:0];
                CFG_CHARGE_RATE: charge_rate_reg <= cfg_data;
                CFG_DRAIN_RATE:  drain_rate_reg  <= cfg_data;
                CFG_COOLDOWN:    cooldown_reg    <= cfg_data[15:0];
                CFG_TILT_OFFSET: tilt_offset_reg <= cfg_data[15:0];
                CFG_GRACE:       grace_reg       <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // stage 1: warm-up, deadbands, tilt clamp, charge or drain choice
    always_comb
    begin
        grace    = in_ts < {16'd0, grace_reg};
        e1_next  = (grace || (in_energy < energy_db_reg)) ? 16'd0 : in_energy;
        rx1_next = grace ? 16'sd0 : dead_rot(in_rot_x, rot_db_reg);
        ry1_next = grace ? 16'sd0 : dead_rot(in_rot_y, rot_db_reg);
        rz1_next = grace ? 16'sd0 : dead_rot(in_rot_z, rot_db_reg);
        chg1_next = e1_next > threshold_reg;

        // tilt minus mounting offset, clamped to +-90 degrees
        // during warm-up the clamp limit gives full scale +1.0
        tdiff = 17'(in_tilt) - 17'(tilt_offset_reg);
        if (grace || (tdiff > TILT_LIMIT))
        begin
            tneg1_next = 1'b0;
            tmag1_next = TILT_LIMIT_MAG;
        end
        else if (tdiff < -TILT_LIMIT)
        begin
            tneg1_next = 1'b1;
            tmag1_next = TILT_LIMIT_MAG;
        end
        else
        begin
            tneg1_next = tdiff[16];
            tmag1_next = tdiff[16] ? 14'(-tdiff) : 14'(tdiff);
        end
    end

    // stage 3 helpers: divide by 1e6 as shift by 6 then /15625, clamped so
    // that anything past one full level reads exactly one full level
    always_comb
    begin
        pdiv = rprod2_reg[47:6];
        nsat = (pdiv >= 42'(DIV_SAT)) ? DIV_SAT : pdiv[29:0];
        tq   = tprod2_reg[TILT_SHIFT+14:TILT_SHIFT];
    end

    // output stage: cooldown, charge or drain with saturation, burst
    always_comb
    begin
        inc  = qprod3_reg[DIV_SHIFT+16:DIV_SHIFT];
        cool = (ts3_reg - last_burst_reg) < {16'd0, cooldown_reg};
        sum  = {1'b0, level_reg} + {1'b0, inc};
        if (chg3_reg)
        begin
            lv = (sum > {1'b0, FULL_LEVEL}) ? FULL_LEVEL : sum[16:0];
        end
        else
        begin
            lv = (inc >= level_reg) ? 17'd0 : level_reg - inc;
        end

        burst           = 1'b0;
        last_burst_next = last_burst_reg;
        if (cool)
        begin
            level_next = '0;
        end
        else if (lv >= FULL_LEVEL)
        begin
            burst           = 1'b1;
            last_burst_next = ts3_reg;
            level_next      = '0;
        end
        else
        begin
            level_next = lv;
        end
        shown = level_next;
    end

    // control: stage valids and overload state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            level_reg      <= '0;
            last_burst_reg <= '0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy_out)
            begin
                out_valid_reg <= v3_reg;
            end
            // state moves once per item, as it enters the output register
            if (rdy_out && v3_reg)
            begin
                level_reg      <= level_next;
                last_burst_reg <= last_burst_next;
            end
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            e1_reg    <= e1_next;
            rx1_reg   <= rx1_next;
            ry1_reg   <= ry1_next;
            rz1_reg   <= rz1_next;
            tneg1_reg <= tneg1_next;
            tmag1_reg <= tmag1_next;
            chg1_reg  <= chg1_next;
            rate1_reg <= chg1_next ? charge_rate_reg : drain_rate_reg;
            dt1_reg   <= in_dt;
            ts1_reg   <= in_ts;
        end
        if (rdy2)
        begin
            e2_reg     <= e1_reg;
            rx2_reg    <= rx1_reg;
            ry2_reg    <= ry1_reg;
            rz2_reg    <= rz1_reg;
            tneg2_reg  <= tneg1_reg;
            tprod2_reg <= 40'(tmag1_reg) * 40'(TILT_RECIP);
            chg2_reg   <= chg1_reg;
            rprod2_reg <= 48'(rate1_reg) * 48'(dt1_reg);
            ts2_reg    <= ts1_reg;
        end
        if (rdy3)
        begin
            e3_reg     <= e2_reg;
            rx3_reg    <= rx2_reg;
            ry3_reg    <= ry2_reg;
            rz3_reg    <= rz2_reg;
            tn3_reg    <= tneg2_reg ? -16'(tq) : 16'(tq);
            chg3_reg   <= chg2_reg;
            qprod3_reg <= 61'(nsat) * 61'(DIV_RECIP);
            ts3_reg    <= ts2_reg;
        end
        if (rdy_out)
        begin
            e_out_reg     <= e3_reg;
            rx_out_reg    <= rx3_reg;
            ry_out_reg    <= ry3_reg;
            rz_out_reg    <= rz3_reg;
            tn_out_reg    <= tn3_reg;
            lvl_out_reg   <= shown;
            burst_out_reg <= burst;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, burst_out_reg, lvl_out_reg, tn_out_reg, rz_out_reg,
                       ry_out_reg, rx_out_reg, e_out_reg};

endmodule
`default_nettype wire
